>>> hw/rtl/cobs_crc16_frame_receiver_assert.svh
// Assertion macros used by the frame receiver checker.
`ifndef COBS_CRC16_FRAME_RECEIVER_ASSERT_SVH
`define COBS_CRC16_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define CCFR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define CCFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ccfr_pkg.sv
// Types, constants and the CRC step shared by the frame receiver modules.
package ccfr_pkg;

    localparam int FRAME_BYTES_DEF = 256;
    localparam int HEADER_BYTES    = 4;
    localparam int CFG_W           = 9;
    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam int QUEUE_DEPTH     = 4;
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_TDATA_W     = 40;

    typedef enum logic [2:0] {
        STS_GOOD     = 3'd0,
        STS_SHORT    = 3'd1,
        STS_OVERRUN  = 3'd2,
        STS_CRC      = 3'd3,
        STS_OVERFLOW = 3'd4
    } frame_status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } result_kind_t;

    // One operation from the front end. For a close, STS_GOOD means the
    // back end settles the status from its own state.
    typedef struct packed {
        logic          close;
        logic [7:0]    data;
        frame_status_t status;
    } fe_op_t;

    typedef struct packed {
        result_kind_t  kind;
        logic [7:0]    payload_byte;
        frame_status_t frame_status;
        logic [7:0]    payload_length;
        logic [15:0]   packet_type;
    } result_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc[15:8] ^ b;
        x = x ^ {4'b0, x[7:4]};
        return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
               ^ {8'h00, x};
    endfunction

endpackage

>>> hw/rtl/ccfr_front.sv
// Front end: takes raw bytes, unstuffs COBS groups and issues decode and close operations.
module ccfr_front #(
    parameter int FRAME_BYTES = ccfr_pkg::FRAME_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ccfr_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    rx_byte,
    input  logic                          q_full,
    output logic                          push,
    output ccfr_pkg::fe_op_t              op
);

    localparam int SCW = $clog2(FRAME_BYTES + 1);
    localparam int LW  = (SCW > ccfr_pkg::CFG_W) ? SCW : ccfr_pkg::CFG_W;

    logic [ccfr_pkg::CFG_W-1:0] max_frame_bytes_reg;
    logic [SCW-1:0]             stuffed_count_reg, stuffed_count_next;
    logic [7:0]                 group_left_reg, group_left_next;
    logic                       group_was_full_reg, group_was_full_next;

    logic [LW-1:0] cfg_ext;
    logic [LW-1:0] limit;
    logic          accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ext   = LW'(max_frame_bytes_reg);
    assign limit     = (cfg_ext > LW'(FRAME_BYTES)) ? LW'(FRAME_BYTES) : cfg_ext;

    always_comb
    begin
        stuffed_count_next  = stuffed_count_reg;
        group_left_next     = group_left_reg;
        group_was_full_next = group_was_full_reg;
        push                = 1'b0;
        op.close            = 1'b0;
        op.data             = rx_byte;
        op.status           = ccfr_pkg::STS_GOOD;
        if (accept)
        begin
            if (rx_byte == 8'h00)
            begin
                push     = (stuffed_count_reg != '0);
                op.close = 1'b1;
                if (stuffed_count_reg < SCW'(ccfr_pkg::HEADER_BYTES))
                begin
                    op.status = ccfr_pkg::STS_SHORT;
                end
                else if (group_left_reg != 8'h00)
                begin
                    op.status = ccfr_pkg::STS_OVERRUN;
                end
                stuffed_count_next  = '0;
                group_left_next     = 8'h00;
                group_was_full_next = 1'b1;
            end
            else if (LW'(stuffed_count_reg) >= limit)
            begin
                push                = 1'b1;
                op.close            = 1'b1;
                op.status           = ccfr_pkg::STS_OVERFLOW;
                stuffed_count_next  = '0;
                group_left_next     = 8'h00;
                group_was_full_next = 1'b1;
            end
            else
            begin
                stuffed_count_next = stuffed_count_reg + SCW'(1);
                if (group_left_reg == 8'h00)
                begin
                    // A code byte first releases the zero owed by the previous group.
                    push                = !group_was_full_reg;
                    op.data             = 8'h00;
                    group_left_next     = rx_byte - 8'd1;
                    group_was_full_next = (rx_byte == 8'hFF);
                end
                else
                begin
                    push            = 1'b1;
                    group_left_next = group_left_reg - 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_bytes_reg <= ccfr_pkg::CFG_RESET;
            stuffed_count_reg   <= '0;
            group_left_reg      <= 8'h00;
            group_was_full_reg  <= 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_frame_bytes_reg <= cfg_data;
            end
            stuffed_count_reg  <= stuffed_count_next;
            group_left_reg     <= group_left_next;
            group_was_full_reg <= group_was_full_next;
        end
    end

endmodule

>>> hw/rtl/ccfr_queue.sv
// Small register queue that decouples the front end from the back end.
module ccfr_queue #(
    parameter int WIDTH = 12,
    parameter int DEPTH = ccfr_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hw/rtl/ccfr_back.sv
// Back end: runs the CRC and header capture and drives the registered result beat.
module ccfr_back #(
    parameter int FRAME_BYTES = ccfr_pkg::FRAME_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    input  ccfr_pkg::fe_op_t   op,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output ccfr_pkg::result_t  res
);

    localparam int SCW = $clog2(FRAME_BYTES + 1);

    logic [SCW-1:0]    decoded_count_reg, decoded_count_next;
    logic [15:0]       running_crc_reg, running_crc_next;
    logic [15:0]       header_crc_reg, header_crc_next;
    logic [15:0]       header_type_reg, header_type_next;
    logic              out_valid_reg, out_valid_next;
    ccfr_pkg::result_t res_reg, res_next;

    logic              emit;
    logic [SCW-1:0]    body_len;
    logic [SCW+7:0]    body_len_w;
    logic [7:0]        len_sat;

    assign pop        = op_valid && (!out_valid_reg || m_tready);
    assign m_tvalid   = out_valid_reg;
    assign res        = res_reg;
    assign body_len   = decoded_count_reg - SCW'(ccfr_pkg::HEADER_BYTES);
    assign body_len_w = {8'h00, body_len};
    assign len_sat    = (body_len_w > (SCW+8)'(255)) ? 8'hFF : body_len_w[7:0];

    always_comb
    begin
        decoded_count_next = decoded_count_reg;
        running_crc_next   = running_crc_reg;
        header_crc_next    = header_crc_reg;
        header_type_next   = header_type_reg;
        res_next           = res_reg;
        emit               = 1'b0;
        if (pop)
        begin
            if (op.close)
            begin
                emit                    = 1'b1;
                res_next.kind           = ccfr_pkg::KIND_STATUS;
                res_next.payload_byte   = 8'h00;
                res_next.payload_length = 8'h00;
                res_next.packet_type    = 16'h0000;
                if (op.status != ccfr_pkg::STS_GOOD)
                begin
                    res_next.frame_status = op.status;
                end
                else if (decoded_count_reg < SCW'(ccfr_pkg::HEADER_BYTES))
                begin
                    res_next.frame_status = ccfr_pkg::STS_SHORT;
                end
                else if (header_crc_reg != running_crc_reg)
                begin
                    res_next.frame_status = ccfr_pkg::STS_CRC;
                end
                else
                begin
                    res_next.frame_status   = ccfr_pkg::STS_GOOD;
                    res_next.payload_length = len_sat;
                    res_next.packet_type    = header_type_reg;
                end
                decoded_count_next = '0;
                running_crc_next   = ccfr_pkg::CRC_INIT;
            end
            else
            begin
                case (decoded_count_reg)
                    SCW'(0):
                    begin
                        header_type_next[7:0] = op.data;
                    end
                    SCW'(1):
                    begin
                        header_type_next[15:8] = op.data;
                    end
                    SCW'(2):
                    begin
                        header_crc_next[7:0] = op.data;
                    end
                    SCW'(3):
                    begin
                        header_crc_next[15:8] = op.data;
                    end
                    default:
                    begin
                        emit = 1'b1;
                    end
                endcase
                // The two header CRC bytes enter the running CRC as zero.
                if (decoded_count_reg == SCW'(2) || decoded_count_reg == SCW'(3))
                begin
                    running_crc_next = ccfr_pkg::crc_update(running_crc_reg, 8'h00);
                end
                else
                begin
                    running_crc_next = ccfr_pkg::crc_update(running_crc_reg, op.data);
                end
                decoded_count_next = decoded_count_reg + SCW'(1);
                if (emit)
                begin
                    res_next.kind           = ccfr_pkg::KIND_PAYLOAD;
                    res_next.payload_byte   = op.data;
                    res_next.frame_status   = ccfr_pkg::STS_GOOD;
                    res_next.payload_length = 8'h00;
                    res_next.packet_type    = 16'h0000;
                end
            end
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        header_crc_reg  <= header_crc_next;
        header_type_reg <= header_type_next;
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decoded_count_reg <= '0;
            running_crc_reg   <= ccfr_pkg::CRC_INIT;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            decoded_count_reg <= decoded_count_next;
            running_crc_reg   <= running_crc_next;
            out_valid_reg     <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/cobs_crc16_frame_receiver.sv
// Top level of the COBS frame receiver with CRC-16/CCITT check.
//
//   Channel  Direction  Beat contents
//   cfg      in         cfg_data: max_frame_bytes (9 bits)
//   s        in         s_tdata[7:0]: rx_byte
//   m        out        m_tuser[0]: result_kind; m_tdata: payload_byte, frame_status,
//                       payload_length, packet_type
//
// One byte is accepted per cycle while the queue is not full; the queue entry is written at
// the accepting edge, and the back end registers any result from the queue head into its
// output register when that register is empty or being taken.
// The queue holds four operations, so up to four more decoded bytes or closes are taken
// while a result waits.
// Reset restarts the counters and the CRC and sets max_frame_bytes to 256.
// A stalled result beat holds until m_tready; the front end stalls only on a full queue.
module cobs_crc16_frame_receiver #(
    parameter int FRAME_BYTES = ccfr_pkg::FRAME_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ccfr_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ccfr_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] rx_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] payload_byte, [10:8] frame_status, [18:11] payload_length,
    // [34:19] packet_type, [39:35] zero
    output logic [ccfr_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic [0:0]                          m_tuser    // [0] result_kind
);

    localparam int OPW = $bits(ccfr_pkg::fe_op_t);

    ccfr_pkg::fe_op_t  fe_op;
    ccfr_pkg::fe_op_t  be_op;
    ccfr_pkg::result_t res;
    logic              fe_push;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;

    ccfr_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .rx_byte  (s_tdata[7:0]),
        .q_full   (q_full),
        .push     (fe_push),
        .op       (fe_op)
    );

    ccfr_queue #(
        .WIDTH(OPW),
        .DEPTH(ccfr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (fe_push),
        .wr_data(fe_op),
        .full   (q_full),
        .pop    (q_pop),
        .valid  (q_valid),
        .rd_data(be_op)
    );

    ccfr_back #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .op_valid(q_valid),
        .op      (be_op),
        .pop     (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .res     (res)
    );

    assign m_tdata = {5'b00000, res.packet_type, res.payload_length, res.frame_status,
                      res.payload_byte};
    assign m_tuser = res.kind;

endmodule

>>> hw/rtl/ccfr_checker.sv
// Port-level checker for the frame receiver, bound to the top level.
`include "cobs_crc16_frame_receiver_assert.svh"

module ccfr_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [ccfr_pkg::CFG_W-1:0]          cfg_data,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [ccfr_pkg::IN_TDATA_W-1:0]     s_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [ccfr_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input logic [0:0]                          m_tuser
);

    `CCFR_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    `CCFR_ASSERT_SAME(a_payload_clean, m_tvalid && (m_tuser[0] == 1'b0), m_tdata[39:8] == 32'h0, "payload beat carries status fields")

    `CCFR_ASSERT_SAME(a_bad_frame_clean, m_tvalid && (m_tuser[0] == 1'b1) && (m_tdata[10:8] != 3'd0), (m_tdata[34:11] == 24'h0) && (m_tdata[7:0] == 8'h00), "failed frame reports length or type")

    `CCFR_ASSERT_SAME(a_status_range, m_tvalid, m_tdata[10:8] <= 3'd4, "status code out of range")

endmodule

bind cobs_crc16_frame_receiver ccfr_checker u_ccfr_checker (.*);
